>>> design/bilinear_resize_sampler_top_assert.svh
// ----------------------------------------------------------------------------
// Bilinear resize sampler assertion macros
// Concurrent assertion shorthands shared by the sampler RTL.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_RESIZE_SAMPLER_TOP_ASSERT_SVH
`define BILINEAR_RESIZE_SAMPLER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/brs_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear resize sampler package
// Shared widths, register indexes, opcodes and interface structs.
// ----------------------------------------------------------------------------
package brs_pkg;

	// Defaults for the top-level parameters
	localparam int FRACTION_BITS = 4;
	localparam int STORE_DEPTH   = 65536;  // power of two: addresses wrap by masking

	// Largest image dimension; larger register values saturate to it
	localparam int MAX_DIM = 4096;

	// Field widths
	localparam int DIM_W      = 13;
	localparam int COORD_W    = 12;
	localparam int STRIDE_W   = 16;
	localparam int CH_W       = 3;
	localparam int CHAN_W     = 2;
	localparam int ADDR_W     = 16;
	localparam int SAMPLE_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// (2i+1)*src and 2*dst
	localparam int POS_W = 2 * DIM_W;
	localparam int DEN_W = DIM_W + 1;

	// Shared multiplier operand width
	localparam int MUL_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 0,
		REG_SRC_HEIGHT = 1,
		REG_SRC_STRIDE = 2,
		REG_DST_WIDTH  = 3,
		REG_DST_HEIGHT = 4,
		REG_CHANNELS   = 5
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Configuration as seen by the datapath, already saturated
	typedef struct packed {
		logic [DIM_W-1:0]    sw;
		logic [DIM_W-1:0]    sh;
		logic [STRIDE_W-1:0] stride;
		logic [DIM_W-1:0]    dw;
		logic [DIM_W-1:0]    dh;
		logic [CH_W-1:0]     ch;
	} cfg_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> design/brs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/brs_cfg.sv
// ----------------------------------------------------------------------------
// Bilinear resize sampler configuration registers
// Holds image geometry, saturating dimensions and the channel count into their legal ranges on write.
// ----------------------------------------------------------------------------
module brs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [brs_pkg::CFG_IDX_W-1:0]      index,
	input  logic [brs_pkg::CFG_DATA_W-1:0]     data,
	output brs_pkg::cfg_t                      cfg
);

	localparam int DW = brs_pkg::DIM_W;
	localparam int CW = brs_pkg::CH_W;

	brs_pkg::cfg_t cfg_q;

	// Clamp a dimension into lo..MAX_DIM
	function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v, input logic [DW-1:0] lo);
		logic [DW-1:0] r;
		if (v < lo) begin
			r = lo;
		end else if (32'(v) > brs_pkg::MAX_DIM) begin
			r = DW'(brs_pkg::MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Clamp the channel count into 1..4
	function automatic logic [CW-1:0] sat_ch(input logic [CW-1:0] v);
		logic [CW-1:0] r;
		if (v == '0) begin
			r = CW'(1);
		end else if (v > CW'(4)) begin
			r = CW'(4);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sw     <= DW'(2);
			cfg_q.sh     <= DW'(2);
			cfg_q.stride <= brs_pkg::STRIDE_W'(2);
			cfg_q.dw     <= DW'(2);
			cfg_q.dh     <= DW'(2);
			cfg_q.ch     <= CW'(1);
		end else if (wr_en) begin
			case (index)
				brs_pkg::REG_SRC_WIDTH:  cfg_q.sw     <= sat_dim(data[DW-1:0], DW'(2));
				brs_pkg::REG_SRC_HEIGHT: cfg_q.sh     <= sat_dim(data[DW-1:0], DW'(2));
				brs_pkg::REG_SRC_STRIDE: cfg_q.stride <= data[brs_pkg::STRIDE_W-1:0];
				brs_pkg::REG_DST_WIDTH:  cfg_q.dw     <= sat_dim(data[DW-1:0], DW'(1));
				brs_pkg::REG_DST_HEIGHT: cfg_q.dh     <= sat_dim(data[DW-1:0], DW'(1));
				brs_pkg::REG_CHANNELS:   cfg_q.ch     <= sat_ch(data[CW-1:0]);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/brs_div.sv
// ----------------------------------------------------------------------------
// Bilinear resize sampler coordinate divider
// Restoring divider, two quotient bits per cycle, shared by both axes.
// ----------------------------------------------------------------------------
module brs_div #(
	parameter int FRACTION_BITS = brs_pkg::FRACTION_BITS
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              start,
	input  logic [brs_pkg::POS_W+FRACTION_BITS:0]             dividend,
	input  logic [brs_pkg::DEN_W-1:0]                         divisor,
	output logic [brs_pkg::POS_W+FRACTION_BITS:0]             quotient,
	output brs_pkg::div_stat_t                                stat
);

	localparam int NUM_W = brs_pkg::POS_W + FRACTION_BITS + 1;
	localparam int STEPS = (NUM_W + 1) / 2;
	localparam int PAD_W = 2 * STEPS;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int DEN_W = brs_pkg::DEN_W;

	logic [PAD_W-1:0] dq_q;     // dividend shifts out, quotient shifts in
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;

	logic [PAD_W-1:0] dq_nx;
	logic [DEN_W-1:0] rem_nx;
	logic [DEN_W:0]   trial;

	// Two restoring steps per cycle
	always_comb begin
		dq_nx  = dq_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_nx, dq_nx[PAD_W-1]};
			dq_nx = {dq_nx[PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial    = trial - {1'b0, den_q};
				dq_nx[0] = 1'b1;
			end
			rem_nx = trial[DEN_W-1:0];
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(STEPS);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Operand load and iteration
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= PAD_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q && cnt_q != '0) begin
			dq_q  <= dq_nx;
			rem_q <= rem_nx;
		end
	end

	assign quotient  = dq_q[NUM_W-1:0];
	assign stat.busy = run_q;
	assign stat.done = run_q && (cnt_q == '0);

endmodule

>>> design/bilinear_resize_sampler_top.sv
// ----------------------------------------------------------------------------
// Bilinear resize sampler
// Source byte store plus a sequencer that maps one destination sample to its
// bilinear value through a shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in_valid / in_ready    | operation, address, value, dst_col, dst_row,
//          |                        | channel
//  out     | out_valid / out_ready  | out_sample
//
//  A load item writes the store directly.
//  A query item uses two divider runs, one per axis.
//  An axis whose position falls below zero skips its divider run.
//  in_ready stays low from query acceptance until the result enters the output
//  register; a result held by out_ready low keeps the sequencer in its last state.
//  Reset clears control state only; the store holds nothing defined until loaded.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "bilinear_resize_sampler_top_assert.svh"

module bilinear_resize_sampler_top #(
	parameter int FRACTION_BITS = brs_pkg::FRACTION_BITS,
	parameter int STORE_DEPTH   = brs_pkg::STORE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brs_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [brs_pkg::ADDR_W-1:0]      address,
	input  logic [brs_pkg::SAMPLE_W-1:0]    value,
	input  logic [brs_pkg::COORD_W-1:0]     dst_col,
	input  logic [brs_pkg::COORD_W-1:0]     dst_row,
	input  logic [brs_pkg::CHAN_W-1:0]      channel,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [brs_pkg::SAMPLE_W-1:0]    out_sample
);

	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int DW     = brs_pkg::DIM_W;
	localparam int POS_W  = brs_pkg::POS_W;
	localparam int DEN_W  = brs_pkg::DEN_W;
	localparam int MUL_W  = brs_pkg::MUL_W;
	localparam int SMP_W  = brs_pkg::SAMPLE_W;
	localparam int WT_W   = FRACTION_BITS + 1;
	localparam int WR_W   = WT_W + 1;
	localparam int NUM_W  = POS_W + WT_W;
	localparam int PRD_W  = 2 * MUL_W;
	localparam int IXC_W  = DW + brs_pkg::CH_W;
	localparam int H_W    = SMP_W + FRACTION_BITS + 1;
	localparam int V_W    = SMP_W + 2 * FRACTION_BITS + 1;
	localparam logic [WT_W-1:0] WT_ONE = WT_W'(1 << FRACTION_BITS);
	localparam logic [V_W-1:0]  V_HALF = V_W'(1 << (2 * FRACTION_BITS - 1));

	typedef enum logic [3:0] {
		S_IDLE,
		S_POS,
		S_DIV,
		S_WAIT,
		S_ADDR,
		S_BASE,
		S_READ,
		S_HORIZ,
		S_VERT
	} state_t;

	// Control registers
	state_t             state_q;
	logic               axis_q;        // 0: horizontal, 1: vertical
	logic [2:0]         rd_cnt_q;
	logic               out_valid_q;
	logic [SMP_W-1:0]   out_sample_q;

	// Datapath registers
	logic [brs_pkg::COORD_W-1:0] col_q;
	logic [brs_pkg::COORD_W-1:0] row_q;
	logic [brs_pkg::CHAN_W-1:0]  chan_q;
	logic [PRD_W-1:0]            mul_q;
	logic [DW-1:0]               ix_q;
	logic [DW-1:0]               iy_q;
	logic [WT_W-1:0]             wx_q;
	logic [WT_W-1:0]             wy_q;
	logic [AW-1:0]               a0_q;
	logic [SMP_W-1:0]            smp_q [4];
	logic [H_W-1:0]              h0_q;
	logic [H_W-1:0]              h1_q;

	brs_pkg::cfg_t      cfg;
	brs_pkg::div_stat_t div_stat;

	logic               accept;
	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [SMP_W-1:0]   ram_rdata;

	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;

	logic [DW-1:0]      src_sel;
	logic [DW-1:0]      dst_sel;
	logic [DW-1:0]      src_lim;
	logic [POS_W-1:0]   pos;
	logic               pos_neg;
	logic               div_start;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic [NUM_W-1:0]   div_quo;
	logic [POS_W-1:0]   quo_int;
	logic [WR_W-1:0]    wt_rnd;
	logic               axis_done;
	logic [DW-1:0]      axis_idx;
	logic [WT_W-1:0]    axis_wt;

	logic [IXC_W-1:0]   ixc;
	logic [1:0]         smp_idx;
	logic [WT_W-1:0]    wx_inv;
	logic [WT_W-1:0]    wy_inv;
	logic [H_W-1:0]     h0_nx;
	logic [H_W-1:0]     h1_nx;
	logic [V_W-1:0]     v_sum;
	logic [SMP_W-1:0]   v_out;
	logic               out_free;

	// Configuration registers
	assign cfg_ready = 1'b1;

	brs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Source store: loads write, the sequencer reads
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign ram_we   = accept && (operation == brs_pkg::OP_LOAD);

	always_comb begin
		ram_raddr = a0_q;
		if (rd_cnt_q[1]) begin
			ram_raddr = ram_raddr + AW'(cfg.stride);
		end
		if (rd_cnt_q[0]) begin
			ram_raddr = ram_raddr + AW'(cfg.ch);
		end
	end

	brs_ram #(
		.WIDTH (SMP_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(address)),
		.wdata (value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared multiplier operands: axis position, then row offset
	always_comb begin
		if (state_q == S_ADDR) begin
			mul_a = MUL_W'(iy_q);
			mul_b = MUL_W'(cfg.stride);
		end else if (axis_q) begin
			mul_a = MUL_W'({row_q, 1'b1});
			mul_b = MUL_W'(cfg.sh);
		end else begin
			mul_a = MUL_W'({col_q, 1'b1});
			mul_b = MUL_W'(cfg.sw);
		end
	end

	// Axis position, division request and clamped index and weight
	always_comb begin
		src_sel   = axis_q ? cfg.sh : cfg.sw;
		dst_sel   = axis_q ? cfg.dh : cfg.dw;
		src_lim   = src_sel - DW'(2);
		pos       = mul_q[POS_W-1:0];
		pos_neg   = pos < POS_W'(dst_sel);
		div_num   = {pos - POS_W'(dst_sel), WT_W'(0)};
		div_den   = {dst_sel, 1'b0};
		div_start = (state_q == S_DIV) && !pos_neg;
		quo_int   = div_quo[NUM_W-1:WT_W];
		wt_rnd    = WR_W'(div_quo[WT_W-1:0]) + 1'b1;
		axis_done = 1'b0;
		axis_idx  = '0;
		axis_wt   = '0;
		if (state_q == S_DIV && pos_neg) begin
			axis_done = 1'b1;
		end else if (state_q == S_WAIT && div_stat.done) begin
			axis_done = 1'b1;
			if (quo_int > POS_W'(src_lim)) begin
				axis_idx = src_lim;
				axis_wt  = WT_ONE;
			end else begin
				axis_idx = quo_int[DW-1:0];
				axis_wt  = wt_rnd[WR_W-1:1];
			end
		end
	end

	brs_div #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Interpolation arithmetic
	always_comb begin
		ixc     = IXC_W'(ix_q) * IXC_W'(cfg.ch);
		smp_idx = 2'(rd_cnt_q - 3'd1);
		wx_inv  = WT_ONE - wx_q;
		wy_inv  = WT_ONE - wy_q;
		h0_nx   = H_W'(smp_q[0]) * H_W'(wx_inv) + H_W'(smp_q[1]) * H_W'(wx_q);
		h1_nx   = H_W'(smp_q[2]) * H_W'(wx_inv) + H_W'(smp_q[3]) * H_W'(wx_q);
		v_sum   = V_W'(h0_q) * V_W'(wy_inv) + V_W'(h1_q) * V_W'(wy_q) + V_HALF;
		v_out   = v_sum[2 * FRACTION_BITS +: SMP_W];
		out_free = !out_valid_q || out_ready;
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			axis_q       <= 1'b0;
			rd_cnt_q     <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
		end else begin
			// drop a taken result; the final state refills the register itself
			if (out_valid_q && out_ready && state_q != S_VERT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && operation == brs_pkg::OP_QUERY) begin
						axis_q  <= 1'b0;
						state_q <= S_POS;
					end
				end
				S_POS: begin
					state_q <= S_DIV;
				end
				S_DIV, S_WAIT: begin
					if (axis_done) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_ADDR : S_POS;
					end else if (state_q == S_DIV) begin
						state_q <= S_WAIT;
					end
				end
				S_ADDR: begin
					state_q <= S_BASE;
				end
				S_BASE: begin
					rd_cnt_q <= '0;
					state_q  <= S_READ;
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 3'd4) begin
						state_q <= S_HORIZ;
					end
				end
				S_HORIZ: begin
					state_q <= S_VERT;
				end
				S_VERT: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= v_out;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		mul_q <= PRD_W'(mul_a) * PRD_W'(mul_b);
		if (accept) begin
			col_q  <= dst_col;
			row_q  <= dst_row;
			chan_q <= channel;
		end
		if (axis_done) begin
			if (axis_q) begin
				iy_q <= axis_idx;
				wy_q <= axis_wt;
			end else begin
				ix_q <= axis_idx;
				wx_q <= axis_wt;
			end
		end
		if (state_q == S_BASE) begin
			a0_q <= mul_q[AW-1:0] + AW'(ixc) + AW'(chan_q);
		end
		if (state_q == S_READ && rd_cnt_q != '0) begin
			smp_q[smp_idx] <= ram_rdata;
		end
		if (state_q == S_HORIZ) begin
			h0_q <= h0_nx;
			h1_q <= h1_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	`BRS_ASSERT_NOW(a_div_done_in_wait, clk, arst_n, div_stat.done, state_q == S_WAIT, "divider finished outside its wait state")
	`BRS_ASSERT_NOW(a_div_start_free, clk, arst_n, div_start, !div_stat.busy, "divider restarted while busy")
	`BRS_ASSERT_NOW(a_wait_has_div, clk, arst_n, state_q == S_WAIT, div_stat.busy, "sequencer waits on an idle divider")
	`BRS_ASSERT_NEXT(a_query_blocks, clk, arst_n, accept && operation == brs_pkg::OP_QUERY, !in_ready, "item accepted during a query")
	`BRS_ASSERT_NOW(a_weight_range, clk, arst_n, state_q == S_HORIZ, (wx_q <= WT_ONE) && (wy_q <= WT_ONE), "weight above one")

endmodule
